>>> hw/rtl/hsv2rgb_pkg.sv
// Package for the HSV to RGB pixel converter: channel width, defaults,
// sector codes and the structures passed between pipeline stages.
// No dependencies.
package hsv2rgb_pkg;

	localparam int CHAN_W = 8;
	localparam int SECTOR_WIDTH_DEF = 16;
	localparam logic [CHAN_W-1:0] WHITE_SCALE_RESET = 8'd15;

	// Hue sectors, named by the two primaries or secondaries at their ends.
	typedef enum logic [2:0] {
		SEC_RED_YELLOW     = 3'd0,
		SEC_YELLOW_GREEN   = 3'd1,
		SEC_GREEN_CYAN     = 3'd2,
		SEC_CYAN_BLUE      = 3'd3,
		SEC_BLUE_MAGENTA   = 3'd4,
		SEC_MAGENTA_RED    = 3'd5
	} sector_t;

	// Values that ride alongside the z calculation.
	typedef struct packed {
		logic [CHAN_W-1:0] high;
		logic [CHAN_W-1:0] low;
		sector_t           sector;
		logic              frac_nz;
	} side_t;

	// Stage enables of the z calculation.
	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} zc_en_t;

	typedef struct packed {
		logic [CHAN_W-1:0] blue;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] red;
	} rgb_t;

endpackage

>>> hw/rtl/hsv_to_rgb_integer.sv
// Integer HSV to RGB converter, six register stages deep.
// An accepted input transaction passes through stages one to six, in order, to its output
// transaction; one pixel is accepted every cycle while the output side takes them.
// Each stage holds at most one pixel and moves on when the stage after it is free,
// so bubbles close up and a stalled output holds six pixels before input stops.
// Reset (arst_n low) empties every stage and sets white_scale to 15.
module hsv_to_rgb_integer #(
	parameter int SECTOR_WIDTH = hsv2rgb_pkg::SECTOR_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // hue [7:0], saturation [15:8], brightness [23:16]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // red [7:0], green [15:8], blue [23:16]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data   // white_scale
);

	localparam int FRAC_W = $clog2(SECTOR_WIDTH);

	logic [hsv2rgb_pkg::CHAN_W-1:0] white_scale_q;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;
	logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

	hsv2rgb_pkg::side_t             side_s1;
	hsv2rgb_pkg::side_t             side_s5;
	logic [FRAC_W-1:0]              frac_s1;
	logic [hsv2rgb_pkg::CHAN_W-1:0] sat_s1;
	logic [hsv2rgb_pkg::CHAN_W-1:0] bright_s1;
	logic [hsv2rgb_pkg::CHAN_W-1:0] z_s5;
	hsv2rgb_pkg::rgb_t              rgb_s6;
	hsv2rgb_pkg::zc_en_t            zc_en;

	// The config register is always ready; the user must write it only when the
	// pipeline is empty (not enforced), so no pixel sees a change part way through.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			white_scale_q <= hsv2rgb_pkg::WHITE_SCALE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			white_scale_q <= cfg_data;
		end
	end

	// A stage may load when it is empty or when its content moves on in the
	// same cycle. The chain runs back from the output handshake.
	assign rdy6 = !valid_s6 || m_tready;
	assign rdy5 = !valid_s5 || rdy6;
	assign rdy4 = !valid_s4 || rdy5;
	assign rdy3 = !valid_s3 || rdy4;
	assign rdy2 = !valid_s2 || rdy3;
	assign rdy1 = !valid_s1 || rdy2;

	assign s_tready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			if (rdy1) begin
				valid_s1 <= s_tvalid;
			end
			if (rdy2) begin
				valid_s2 <= valid_s1;
			end
			if (rdy3) begin
				valid_s3 <= valid_s2;
			end
			if (rdy4) begin
				valid_s4 <= valid_s3;
			end
			if (rdy5) begin
				valid_s5 <= valid_s4;
			end
			if (rdy6) begin
				valid_s6 <= valid_s5;
			end
		end
	end

	assign zc_en = '{s2: rdy2, s3: rdy3, s4: rdy4, s5: rdy5};

	hsv2rgb_front #(
		.SECTOR_WIDTH (SECTOR_WIDTH)
	) u_front (
		.clk         (clk),
		.en          (rdy1),
		.hue         (s_tdata[7:0]),
		.saturation  (s_tdata[15:8]),
		.brightness  (s_tdata[23:16]),
		.white_scale (white_scale_q),
		.side_s1     (side_s1),
		.frac_s1     (frac_s1),
		.sat_s1      (sat_s1),
		.bright_s1   (bright_s1)
	);

	hsv2rgb_zcalc #(
		.SECTOR_WIDTH (SECTOR_WIDTH)
	) u_zcalc (
		.clk       (clk),
		.en        (zc_en),
		.side_s1   (side_s1),
		.frac_s1   (frac_s1),
		.sat_s1    (sat_s1),
		.bright_s1 (bright_s1),
		.side_s5   (side_s5),
		.z_s5      (z_s5)
	);

	hsv2rgb_mix u_mix (
		.clk     (clk),
		.en      (rdy6),
		.side_s5 (side_s5),
		.z_s5    (z_s5),
		.rgb_s6  (rgb_s6)
	);

	assign m_tvalid = valid_s6;
	assign m_tdata  = {rgb_s6.blue, rgb_s6.green, rgb_s6.red};

	// With every stage full and the output stalled, no new pixel may enter.
	a_full_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && valid_s3 && valid_s4 && valid_s5 && valid_s6
			&& !m_tready) |-> !s_tready)
		else $error("input accepted while the pipeline is full and stalled");

	// A free output lets every stage advance, so the input is then ready.
	a_ready_passes: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("input not ready although the output side is ready");

	// The hue table yields only the six sector codes.
	a_sector_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (side_s1.sector <= hsv2rgb_pkg::SEC_MAGENTA_RED))
		else $error("sector code out of range in stage one");

	// A pixel in the last stage that is not taken stays there.
	a_out_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s6 && !m_tready) |=> (valid_s6 && $stable(rgb_s6)))
		else $error("stalled result lost or changed");

endmodule

>>> hw/rtl/hsv2rgb_front.sv
// First pipeline stage: hue lookup (fraction and sector) and the high and
// low channel products. Depends on hsv2rgb_pkg.
module hsv2rgb_front #(
	parameter int SECTOR_WIDTH = hsv2rgb_pkg::SECTOR_WIDTH_DEF,
	localparam int FRAC_W = $clog2(SECTOR_WIDTH)
) (
	input  logic                            clk,
	input  logic                            en,
	input  logic [hsv2rgb_pkg::CHAN_W-1:0]  hue,
	input  logic [hsv2rgb_pkg::CHAN_W-1:0]  saturation,
	input  logic [hsv2rgb_pkg::CHAN_W-1:0]  brightness,
	input  logic [hsv2rgb_pkg::CHAN_W-1:0]  white_scale,
	output hsv2rgb_pkg::side_t              side_s1,
	output logic [FRAC_W-1:0]               frac_s1,
	output logic [hsv2rgb_pkg::CHAN_W-1:0]  sat_s1,
	output logic [hsv2rgb_pkg::CHAN_W-1:0]  bright_s1
);

	localparam int HUE_N = 2 ** hsv2rgb_pkg::CHAN_W;
	localparam int PROD_W = 2 * hsv2rgb_pkg::CHAN_W;

	logic [FRAC_W-1:0]          frac_tab [HUE_N];
	hsv2rgb_pkg::sector_t       sec_tab  [HUE_N];
	logic [hsv2rgb_pkg::CHAN_W-1:0] diff;
	logic [PROD_W-1:0]          high_full;
	logic [PROD_W-1:0]          low_full;

	// Constant tables of the hue split into sector and position within it.
	for (genvar i = 0; i < HUE_N; i++) begin : g_tab
		localparam int FRAC = i % SECTOR_WIDTH;
		localparam int SEC  = (i % (6 * SECTOR_WIDTH)) / SECTOR_WIDTH;
		assign frac_tab[i] = FRAC_W'(FRAC);
		assign sec_tab[i]  = hsv2rgb_pkg::sector_t'(3'(SEC));
	end

	assign diff      = white_scale - saturation;
	assign high_full = PROD_W'(brightness) * PROD_W'(white_scale);
	assign low_full  = PROD_W'(brightness) * PROD_W'(diff);

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1.high    <= high_full[hsv2rgb_pkg::CHAN_W-1:0];
			side_s1.low     <= low_full[hsv2rgb_pkg::CHAN_W-1:0];
			side_s1.sector  <= sec_tab[hue];
			side_s1.frac_nz <= (frac_tab[hue] != '0);
			frac_s1         <= frac_tab[hue];
			sat_s1          <= saturation;
			bright_s1       <= brightness;
		end
	end

endmodule

>>> hw/rtl/hsv2rgb_zcalc.sv
// Stages two to five: z = saturation * ((brightness * frac) mod 256) / width,
// the division done as a reciprocal multiply with a one-step correction.
// Depends on hsv2rgb_pkg.
module hsv2rgb_zcalc #(
	parameter int SECTOR_WIDTH = hsv2rgb_pkg::SECTOR_WIDTH_DEF,
	localparam int FRAC_W = $clog2(SECTOR_WIDTH)
) (
	input  logic                            clk,
	input  hsv2rgb_pkg::zc_en_t             en,
	input  hsv2rgb_pkg::side_t              side_s1,
	input  logic [FRAC_W-1:0]               frac_s1,
	input  logic [hsv2rgb_pkg::CHAN_W-1:0]  sat_s1,
	input  logic [hsv2rgb_pkg::CHAN_W-1:0]  bright_s1,
	output hsv2rgb_pkg::side_t              side_s5,
	output logic [hsv2rgb_pkg::CHAN_W-1:0]  z_s5
);

	localparam int CW        = hsv2rgb_pkg::CHAN_W;
	localparam int VF_W      = CW + FRAC_W;
	localparam int N_W       = 2 * CW;
	localparam int DIV_SHIFT = N_W + CW;
	localparam int MULT_W    = DIV_SHIFT;
	localparam logic [MULT_W-1:0] DIV_MULT = MULT_W'((2 ** DIV_SHIFT) / SECTOR_WIDTH);
	localparam int PROD_W    = N_W + MULT_W;
	localparam int QW_W      = 32;

	logic [VF_W-1:0]   vf_full;
	logic [PROD_W-1:0] recip_full;
	logic [QW_W-1:0]   qw_full;
	logic [N_W-1:0]    rem;

	hsv2rgb_pkg::side_t side_s2, side_s3, side_s4;
	logic [CW-1:0]  vf_s2;
	logic [CW-1:0]  sat_s2;
	logic [N_W-1:0] n_s3;
	logic [N_W-1:0] n_s4;
	logic [N_W-1:0] q_s4;

	assign vf_full    = VF_W'(bright_s1) * VF_W'(frac_s1);
	assign recip_full = PROD_W'(n_s3) * PROD_W'(DIV_MULT);
	assign qw_full    = QW_W'(q_s4) * QW_W'(SECTOR_WIDTH);
	assign rem        = n_s4 - qw_full[N_W-1:0];

	always_ff @(posedge clk) begin
		if (en.s2) begin
			vf_s2   <= vf_full[CW-1:0];
			sat_s2  <= sat_s1;
			side_s2 <= side_s1;
		end
		if (en.s3) begin
			n_s3    <= N_W'(sat_s2) * N_W'(vf_s2);
			side_s3 <= side_s2;
		end
		if (en.s4) begin
			// Estimate is the true quotient or one below it.
			q_s4    <= recip_full[PROD_W-1:DIV_SHIFT];
			n_s4    <= n_s3;
			side_s4 <= side_s3;
		end
		if (en.s5) begin
			z_s5    <= q_s4[CW-1:0] + CW'(rem >= N_W'(SECTOR_WIDTH));
			side_s5 <= side_s4;
		end
	end

endmodule

>>> hw/rtl/hsv2rgb_mix.sv
// Final stage: forms the rising and falling levels and routes the four
// levels onto red, green and blue by sector. Depends on hsv2rgb_pkg.
module hsv2rgb_mix (
	input  logic                            clk,
	input  logic                            en,
	input  hsv2rgb_pkg::side_t              side_s5,
	input  logic [hsv2rgb_pkg::CHAN_W-1:0]  z_s5,
	output hsv2rgb_pkg::rgb_t               rgb_s6
);

	logic [hsv2rgb_pkg::CHAN_W-1:0] rising;
	logic [hsv2rgb_pkg::CHAN_W-1:0] falling;
	hsv2rgb_pkg::rgb_t              rgb;

	always_comb begin
		if (side_s5.frac_nz) begin
			rising  = side_s5.low + z_s5;
			falling = side_s5.high - z_s5 - 8'd1;
		end else begin
			rising  = side_s5.low;
			falling = side_s5.high;
		end
	end

	always_comb begin
		unique case (side_s5.sector)
			hsv2rgb_pkg::SEC_RED_YELLOW: begin
				rgb = '{blue: side_s5.low, green: rising, red: side_s5.high};
			end
			hsv2rgb_pkg::SEC_YELLOW_GREEN: begin
				rgb = '{blue: side_s5.low, green: side_s5.high, red: falling};
			end
			hsv2rgb_pkg::SEC_GREEN_CYAN: begin
				rgb = '{blue: rising, green: side_s5.high, red: side_s5.low};
			end
			hsv2rgb_pkg::SEC_CYAN_BLUE: begin
				rgb = '{blue: side_s5.high, green: falling, red: side_s5.low};
			end
			hsv2rgb_pkg::SEC_BLUE_MAGENTA: begin
				rgb = '{blue: side_s5.high, green: side_s5.low, red: rising};
			end
			default: begin
				rgb = '{blue: falling, green: side_s5.low, red: side_s5.high};
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rgb_s6 <= rgb;
		end
	end

endmodule
